/* design/lpfd_pkg.sv */
// shared constants and types for the length-prefixed frame deframer
package lpfd_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int LEN_BYTES    = 4;
  localparam int TYPE_BYTES   = 2;
  localparam int CNT_W        = 4;

  localparam logic [CNT_W-1:0] TYPE_START = CNT_W'(LEN_BYTES);
  localparam logic [CNT_W-1:0] ID_START   = CNT_W'(LEN_BYTES + TYPE_BYTES);
  localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(HEADER_BYTES - 1);

  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic [15:0] frame_type;
    logic [31:0] frame_id;
    logic        empty_frame;
    logic        last;
  } result_t;

endpackage

/* design/lpfd_parser.sv */
// frame header capture and payload tracking, one byte per step
module lpfd_parser import lpfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [31:0]   session,
  input  logic [7:0]    stream_byte,
  input  logic [31:0]   own_session,
  output result_t       result
);

  logic [CNT_W-1:0] header_count, header_count_next;
  logic             in_payload, in_payload_next;
  logic [31:0]      length_word, length_word_next;
  logic [15:0]      type_word, type_word_next;
  logic [31:0]      id_word, id_word_next;
  logic [30:0]      bytes_left, bytes_left_next;
  logic             match;
  logic             fin;

  assign match = (session == own_session);
  assign fin   = (bytes_left <= 31'd1);

  always_comb begin
    header_count_next = header_count;
    in_payload_next   = in_payload;
    length_word_next  = length_word;
    type_word_next    = type_word;
    id_word_next      = id_word;
    bytes_left_next   = bytes_left;
    result            = '0;
    if (match) begin
      if (in_payload) begin
        result.valid        = 1'b1;
        result.payload_byte = stream_byte;
        result.frame_type   = type_word;
        result.frame_id     = id_word;
        result.last         = fin;
        if (fin) begin
          bytes_left_next   = '0;
          in_payload_next   = 1'b0;
          header_count_next = '0;
        end else begin
          bytes_left_next = bytes_left - 31'd1;
        end
      end else begin
        // big-endian capture: length, then type, then id
        if (header_count < TYPE_START) begin
          length_word_next = {length_word[23:0], stream_byte};
        end else if (header_count < ID_START) begin
          type_word_next = {type_word[7:0], stream_byte};
        end else begin
          id_word_next = {id_word[23:0], stream_byte};
        end
        header_count_next = header_count + CNT_W'(1);
        if (header_count == HDR_LAST) begin
          header_count_next = '0;
          if (length_word[31] || length_word == 32'd0) begin
            // an empty frame, or a length with bit 31 set, gives one marker result
            result.valid       = 1'b1;
            result.frame_type  = type_word_next;
            result.frame_id    = id_word_next;
            result.empty_frame = 1'b1;
            result.last        = 1'b1;
          end else begin
            bytes_left_next = length_word[30:0];
            in_payload_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      in_payload   <= 1'b0;
      length_word  <= '0;
      type_word    <= '0;
      id_word      <= '0;
      bytes_left   <= '0;
    end else if (step) begin
      header_count <= header_count_next;
      in_payload   <= in_payload_next;
      length_word  <= length_word_next;
      type_word    <= type_word_next;
      id_word      <= id_word_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

/* design/length_prefixed_frame_deframer_core.sv */
// top level of the length-prefixed frame deframer
// a request taken into the input register passes through the parser into the result register
// throughput: one byte per cycle while out_stall is low, set by the single-stage parser
// an output held by stall backs up through the input register to in_stall
// reset (rst, synchronous, active high) clears the valids, the frame state
// and own_session to zero
module length_prefixed_frame_deframer_core import lpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] session,
  input  logic [7:0]  stream_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic [15:0] frame_type,
  output logic [31:0] frame_id,
  output logic        empty_frame,
  output logic        last
);

  logic [31:0] own_session;

  // input register
  logic        s1_valid;
  logic [31:0] s1_session;
  logic [7:0]  s1_byte;

  // result register
  result_t     res;
  result_t     res_reg;

  logic        out_free;
  logic        step;

  // result register can load when empty or being drained this cycle
  assign out_free = !res_reg.valid || !out_stall;
  // the held request moves through the parser whenever the result side is free
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_session <= '0;
    end else if (cfg_write) begin
      own_session <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_session <= session;
      s1_byte    <= stream_byte;
    end
  end

  lpfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .session     (s1_session),
    .stream_byte (s1_byte),
    .own_session (own_session),
    .result      (res)
  );

  // result register: valid is reset, the fields load only when the parser
  // produced a result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_reg.valid <= 1'b0;
    end else if (out_free) begin
      res_reg.valid <= step && res.valid;
    end
    if (out_free && step && res.valid) begin
      res_reg.payload_byte <= res.payload_byte;
      res_reg.frame_type   <= res.frame_type;
      res_reg.frame_id     <= res.frame_id;
      res_reg.empty_frame  <= res.empty_frame;
      res_reg.last         <= res.last;
    end
  end

  assign out_valid    = res_reg.valid;
  assign payload_byte = res_reg.payload_byte;
  assign frame_type   = res_reg.frame_type;
  assign frame_id     = res_reg.frame_id;
  assign empty_frame  = res_reg.empty_frame;
  assign last         = res_reg.last;

endmodule
